// ----- src/sldf_pkg.sv -----
// shared types and constants of the framed byte-stream deframer
// no dependencies; imported by the core and by its checker
`default_nettype none

package sldf_pkg;

   // frame geometry
   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned LENGTH_BYTES = 2;
   localparam int unsigned LEN_FIRST    = HEADER_BYTES - LENGTH_BYTES;

   // field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned RSP_W   = 48;
   localparam logic [7:0]  START_BYTE_RESET = 8'd35;

   // header counter limits at the counter width
   localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(HEADER_BYTES - 1);
   localparam logic [POS_W-1:0] LEN_START = POS_W'(LEN_FIRST);
   localparam logic [POS_W-1:0] HDR_FIRST = POS_W'(2);

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CHECK   = 2'd3
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

endpackage

`default_nettype wire

// ----- src/sync_length_frame_deframer_bcc_core.sv -----
// a result is registered and appears on rsp_tvalid in the cycle after its byte is accepted
// throughput: one byte per cycle; req_tready stays high while the result
// register is empty or being emptied, so only rsp_tready stalls the input
// hunt bytes and start bytes give no result transaction
// reset (synchronous, active high): hunt phase, counters and xor cleared,
// start byte back to 35, result register empty
`default_nettype none

module sync_length_frame_deframer_bcc_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write: start byte
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data,
   // received bytes; tdata: rx_byte[7:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: data_byte[7:0], offset[23:8], check_ok[24], payload_length[40:25], zero[47:41]
   output logic [47:0]      rsp_tdata,
   // tuser: kind[1:0]
   output logic [1:0]       rsp_tuser
);
   import sldf_pkg::*;

   // state
   phase_type          phase_ff, phase_in;
   logic               start_seen_ff, start_seen_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [POS_W-1:0]   length_ff, length_in;
   logic [BYTE_W-1:0]  xor_ff, xor_in;
   logic [BYTE_W-1:0]  start_byte_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           kind_ff, kind_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic [POS_W-1:0]   offset_ff, offset_in;
   logic               ok_ff, ok_in;
   logic [POS_W-1:0]   len_out_ff, len_out_in;

   logic               accept;
   logic               produce;
   logic [BYTE_W-1:0]  rx_byte;
   logic [POS_W-1:0]   len_rel;
   logic [POS_W:0]     pay_next;

   assign csr_ready  = 1'b1;
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign rx_byte    = req_tdata;
   assign len_rel    = position_ff - LEN_START;
   assign pay_next   = {1'b0, position_ff} + {{POS_W{1'b0}}, 1'b1};

   // next state and result for the byte in flight
   always_comb begin
      phase_in      = phase_ff;
      start_seen_in = start_seen_ff;
      position_in   = position_ff;
      length_in     = length_ff;
      xor_in        = xor_ff;
      produce       = 1'b0;
      kind_in       = KIND_HEADER;
      data_in       = rx_byte;
      offset_in     = position_ff;
      ok_in         = 1'b0;
      len_out_in    = length_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == start_byte_ff) begin
               if (start_seen_ff) begin
                  start_seen_in = 1'b0;
                  phase_in      = PH_HEADER;
                  position_in   = HDR_FIRST;
                  length_in     = '0;
                  xor_in        = '0;
               end else begin
                  start_seen_in = 1'b1;
               end
            end else begin
               start_seen_in = 1'b0;
            end
         end
         PH_HEADER: begin
            produce = 1'b1;
            xor_in  = xor_ff ^ rx_byte;
            // little-endian length bytes at the end of the header
            if (position_ff >= LEN_START) begin
               if (len_rel[0]) begin
                  length_in = length_ff | {rx_byte, 8'h00};
               end else begin
                  length_in = length_ff | {8'h00, rx_byte};
               end
            end
            kind_in    = KIND_HEADER;
            len_out_in = length_in;
            if (position_ff >= HDR_LAST) begin
               position_in = '0;
               phase_in    = (length_in == '0) ? PH_CHECK : PH_PAYLOAD;
            end else begin
               position_in = pay_next[POS_W-1:0];
            end
         end
         PH_PAYLOAD: begin
            produce = 1'b1;
            xor_in  = xor_ff ^ rx_byte;
            kind_in = KIND_PAYLOAD;
            if (pay_next >= {1'b0, length_ff}) begin
               position_in = '0;
               phase_in    = PH_CHECK;
            end else begin
               position_in = pay_next[POS_W-1:0];
            end
         end
         PH_CHECK: begin
            produce       = 1'b1;
            kind_in       = KIND_END;
            offset_in     = '0;
            ok_in         = (xor_ff == rx_byte);
            phase_in      = PH_HUNT;
            start_seen_in = 1'b0;
            position_in   = '0;
            xor_in        = '0;
         end
      endcase
   end

   // result register occupancy
   always_comb begin
      if (accept) begin
         rsp_valid_in = produce;
      end else begin
         rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         start_seen_ff <= 1'b0;
         position_ff   <= '0;
         length_ff     <= '0;
         xor_ff        <= '0;
         start_byte_ff <= START_BYTE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            start_seen_ff <= start_seen_in;
            position_ff   <= position_in;
            length_ff     <= length_in;
            xor_ff        <= xor_in;
         end
         if (csr_valid & csr_ready) begin
            start_byte_ff <= csr_data;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept & produce) begin
         kind_ff    <= kind_in;
         data_ff    <= data_in;
         offset_ff  <= offset_in;
         ok_ff      <= ok_in;
         len_out_ff <= len_out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {7'd0, len_out_ff, ok_ff, offset_ff, data_ff};

endmodule

`default_nettype wire

// ----- src/sldf_checker.sv -----
// port-level checks of the deframer core, attached by bind
// depends on sldf_pkg and on sync_length_frame_deframer_bcc_core
`default_nettype none

module sldf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   import sldf_pkg::*;

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // every result comes from an accepted byte or was already waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $past(req_tvalid && req_tready) || $past(rsp_tvalid && !rsp_tready))
      else $error("result without a source transaction");

   // only three kinds exist
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == KIND_HEADER || rsp_tuser == KIND_PAYLOAD
                     || rsp_tuser == KIND_END)
      else $error("bad result kind");

   // check flag only at frame end, offset zero there
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_END |-> rsp_tdata[24] == 1'b0)
      else $error("check flag outside frame end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tdata[23:8] == 16'd0)
      else $error("nonzero offset at frame end");

endmodule

bind sync_length_frame_deframer_bcc_core sldf_checker u_sldf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
